/* design/dpu_pkg.sv */
// Shared types, widths and helpers for the depth pixel unprojection core.
// No dependencies; every other design file imports this package.
`default_nettype none

package dpu_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int DEPTH_W   = 25;
    localparam int ELEM_W    = 21;
    localparam int NDC_W     = 38;
    localparam int NZ_W      = 28;
    localparam int H_W       = 62;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;

    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(16777216);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PACK_A,
        REG_PACK_B,
        REG_PACK_C,
        REG_PACK_D,
        REG_PACK_E,
        REG_PACK_F,
        REG_IMAGE_SIZE,
        REG_FULL_MODE
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
        logic [DEPTH_W-1:0] depth_sample;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               w_zero;
    } point_t;

    // pass-through part of an item
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } side_t;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef elem_t [15:0] matrix_t;

    // device coordinates of one item
    typedef struct packed {
        side_t                   sb;
        logic signed [NDC_W-1:0] nx;
        logic signed [NDC_W-1:0] ny;
        logic signed [NZ_W-1:0]  nz;
    } vec_t;

    // homogeneous point of one item
    typedef struct packed {
        side_t                      sb;
        logic signed [3:0][H_W-1:0] h;
    } hom_t;

    // background depth reads as zero
    function automatic logic [DEPTH_W-1:0] bg_map(input logic [DEPTH_W-1:0] d);
        return (d == DEPTH_ONE) ? '0 : d;
    endfunction

endpackage

`default_nettype wire

/* design/dpu_ndc.sv */
// Device coordinate stage: pixel centre over image size, one radix-16 step per stage.
// Depends on dpu_pkg.
`default_nettype none

module dpu_ndc
    import dpu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire pixel_t           in_pix,
    input  wire logic [DIM_W-1:0] dim_x,
    input  wire logic [DIM_W-1:0] dim_y,
    output logic                  out_valid,
    output vec_t                  out_vec
);

    localparam int NSTG = 10;

    typedef struct packed {
        side_t                  sb;
        logic signed [NZ_W-1:0] nz;
        logic                   neg_x;
        logic                   neg_y;
        logic [39:0]            word_x;
        logic [39:0]            word_y;
        logic [11:0]            rem_x;
        logic [11:0]            rem_y;
    } nstage_t;

    nstage_t    st_reg [NSTG+1];
    nstage_t    st_next[NSTG+1];
    logic [NSTG+1:0] vld_reg;
    vec_t       vec_reg;

    // four restoring steps; returns {rem, word}
    function automatic logic [51:0] div4(input logic [39:0] word, input logic [11:0] rem,
                                         input logic [DIM_W-1:0] dim);
        logic [39:0] w;
        logic [12:0] r2;
        logic [11:0] r;
        w = word;
        r = rem;
        for (int j = 0; j < 4; j++) begin
            r2 = {r, w[39]};
            w  = {w[38:0], 1'b0};
            if (r2 >= dim) begin
                r2   = r2 - dim;
                w[0] = 1'b1;
            end
            r = r2[11:0];
        end
        return {r, w};
    endfunction

    logic signed [14:0]  n_x, n_y;
    logic [14:0]         a_x, a_y;
    logic [DEPTH_W-1:0]  dmap;

    always_comb begin
        dmap = bg_map(in_pix.depth_sample);
        n_x  = $signed({2'b0, in_pix.pixel_col, 1'b1}) - $signed({2'b0, dim_x});
        n_y  = $signed({2'b0, in_pix.pixel_row, 1'b1}) - $signed({2'b0, dim_y});
        a_x  = n_x[14] ? 15'(-n_x) : 15'(n_x);
        a_y  = n_y[14] ? 15'(-n_y) : 15'(n_y);

        st_next[0].sb     = '{col: in_pix.pixel_col, row: in_pix.pixel_row,
                              red: in_pix.red, green: in_pix.green, blue: in_pix.blue};
        st_next[0].nz     = $signed({2'b0, dmap, 1'b0}) - $signed(NZ_W'(DEPTH_ONE));
        st_next[0].neg_x  = n_x[14];
        st_next[0].neg_y  = n_y[14];
        // magnitude in Q.24 plus half the divisor for rounding
        st_next[0].word_x = {3'b0, a_x[12:0], 24'b0} + {28'b0, dim_x[DIM_W-1:1]};
        st_next[0].word_y = {3'b0, a_y[12:0], 24'b0} + {28'b0, dim_y[DIM_W-1:1]};
        st_next[0].rem_x  = '0;
        st_next[0].rem_y  = '0;

        for (int s = 1; s <= NSTG; s++) begin
            st_next[s] = st_reg[s-1];
            {st_next[s].rem_x, st_next[s].word_x} =
                div4(st_reg[s-1].word_x, st_reg[s-1].rem_x, dim_x);
            {st_next[s].rem_y, st_next[s].word_y} =
                div4(st_reg[s-1].word_y, st_reg[s-1].rem_y, dim_y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= NSTG; s++)
                st_reg[s] <= st_next[s];
            vec_reg.sb <= st_reg[NSTG].sb;
            vec_reg.nz <= st_reg[NSTG].nz;
            vec_reg.nx <= st_reg[NSTG].neg_x ? -$signed(st_reg[NSTG].word_x[NDC_W-1:0])
                                             :  $signed(st_reg[NSTG].word_x[NDC_W-1:0]);
            vec_reg.ny <= st_reg[NSTG].neg_y ? -$signed(st_reg[NSTG].word_y[NDC_W-1:0])
                                             :  $signed(st_reg[NSTG].word_y[NDC_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG:0], in_valid};
    end

    assign out_valid = vld_reg[NSTG+1];
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

/* design/dpu_mat.sv */
// Matrix stage: 4x4 inverse projection times the device point, three register stages.
// Depends on dpu_pkg.
`default_nettype none

module dpu_mat
    import dpu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire vec_t    in_vec,
    input  wire matrix_t mat,
    output logic         out_valid,
    output hom_t         out_hom
);

    typedef struct packed {
        side_t                          sb;
        logic signed [3:0][1:0][41:0]   plo;
        logic signed [3:0][1:0][38:0]   phi;
        logic signed [3:0][48:0]        p2;
        logic signed [3:0][ELEM_W-1:0]  m3;
    } prod_t;

    typedef struct packed {
        side_t                      sb;
        logic signed [3:0][H_W-1:0] e0;
        logic signed [3:0][H_W-1:0] e1;
        logic signed [3:0][H_W-1:0] e2;
    } part_t;

    prod_t      a_reg, a_next;
    part_t      b_reg, b_next;
    hom_t       c_reg, c_next;
    logic [2:0] vld_reg;

    always_comb begin
        a_next.sb = in_vec.sb;
        // x and y split into low and high halves to keep each multiplier narrow
        for (int r = 0; r < 4; r++) begin
            a_next.plo[r][0] = $signed(mat[4*r])   * $signed({1'b0, in_vec.nx[19:0]});
            a_next.phi[r][0] = $signed(mat[4*r])   * $signed(in_vec.nx[NDC_W-1:20]);
            a_next.plo[r][1] = $signed(mat[4*r+1]) * $signed({1'b0, in_vec.ny[19:0]});
            a_next.phi[r][1] = $signed(mat[4*r+1]) * $signed(in_vec.ny[NDC_W-1:20]);
            a_next.p2[r]     = $signed(mat[4*r+2]) * in_vec.nz;
            a_next.m3[r]     = mat[4*r+3];
        end

        b_next.sb = a_reg.sb;
        // element selects come out unsigned; sign-extend each partial product
        for (int r = 0; r < 4; r++) begin
            b_next.e0[r] = (H_W'($signed(a_reg.phi[r][0])) <<< 20)
                         + H_W'($signed(a_reg.plo[r][0]));
            b_next.e1[r] = (H_W'($signed(a_reg.phi[r][1])) <<< 20)
                         + H_W'($signed(a_reg.plo[r][1]));
            b_next.e2[r] = H_W'($signed(a_reg.p2[r]))
                         + (H_W'($signed(a_reg.m3[r])) <<< 24);
        end

        c_next.sb = b_reg.sb;
        for (int r = 0; r < 4; r++)
            c_next.h[r] = b_reg.e0[r] + b_reg.e1[r] + b_reg.e2[r];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    assign out_valid = vld_reg[2];
    assign out_hom   = c_reg;

endmodule

`default_nettype wire

/* design/dpu_wdiv.sv */
// Perspective divide: three numerators over w, one quotient bit per stage, rounding
// and saturation at the end. Depends on dpu_pkg.
`default_nettype none

module dpu_wdiv
    import dpu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire hom_t in_hom,
    output logic      out_valid,
    output point_t    out_point
);

    localparam int QB   = 32;
    localparam int AW   = H_W - 1;
    localparam int RW   = AW + QB;
    localparam int NSTG = QB + 2;

    typedef struct packed {
        side_t                  sb;
        logic [2:0]             neg;
        logic [2:0]             npos;
        logic [2:0]             nneg;
        logic                   bz;
        logic [2:0]             sat;
        logic [AW-1:0]          b;
        logic [2:0][RW-1:0]     rem;
        logic [2:0][QB-1:0]     q;
    } dstage_t;

    dstage_t         st_reg [NSTG];
    dstage_t         st_next[NSTG];
    logic [NSTG:0]   vld_reg;
    point_t          pt_reg, pt_next;

    logic [H_W-1:0]  mag [4];
    logic [RW-1:0]   dsh [NSTG];
    logic [32:0]     rnd_w [3];
    logic [31:0]     rnd [3];
    logic [31:0]     res [3];

    always_comb begin
        for (int i = 0; i < 4; i++)
            mag[i] = in_hom.h[i][H_W-1] ? H_W'(-in_hom.h[i]) : H_W'(in_hom.h[i]);

        st_next[0].sb  = in_hom.sb;
        st_next[0].b   = mag[3][AW-1:0];
        st_next[0].bz  = (in_hom.h[3] == '0);
        st_next[0].sat = '0;
        for (int i = 0; i < 3; i++) begin
            st_next[0].neg[i]  = in_hom.h[i][H_W-1] ^ in_hom.h[3][H_W-1];
            st_next[0].nneg[i] = in_hom.h[i][H_W-1];
            st_next[0].npos[i] = !in_hom.h[i][H_W-1] && (in_hom.h[i] != '0);
            st_next[0].rem[i]  = {{(RW-AW-17){1'b0}}, mag[i][AW-1:0], 17'b0};
            st_next[0].q[i]    = '0;
        end

        // integer part of 2^15 or more saturates
        st_next[1] = st_reg[0];
        for (int i = 0; i < 3; i++)
            st_next[1].sat[i] = st_reg[0].rem[i][AW+16:17] >= {st_reg[0].b, 15'b0};

        dsh[0] = '0;
        dsh[1] = '0;
        for (int s = 2; s < NSTG; s++) begin
            st_next[s] = st_reg[s-1];
            dsh[s]     = {{(RW-AW){1'b0}}, st_reg[s-1].b} << (NSTG - 1 - s);
            for (int i = 0; i < 3; i++) begin
                if (st_reg[s-1].rem[i] >= dsh[s]) begin
                    st_next[s].rem[i] = st_reg[s-1].rem[i] - dsh[s];
                    st_next[s].q[i]   = {st_reg[s-1].q[i][QB-2:0], 1'b1};
                end
                else
                    st_next[s].q[i]   = {st_reg[s-1].q[i][QB-2:0], 1'b0};
            end
        end

        for (int i = 0; i < 3; i++) begin
            rnd_w[i] = {1'b0, st_reg[NSTG-1].q[i]} + 33'd1;
            rnd[i]   = rnd_w[i][32:1];
            if (st_reg[NSTG-1].bz)
                res[i] = st_reg[NSTG-1].npos[i] ? 32'h7FFF_FFFF :
                         st_reg[NSTG-1].nneg[i] ? 32'h8000_0000 : 32'h0;
            else if (st_reg[NSTG-1].sat[i])
                res[i] = st_reg[NSTG-1].neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else if (st_reg[NSTG-1].neg[i])
                res[i] = 32'(-rnd[i]);
            else
                res[i] = rnd[i][31] ? 32'h7FFF_FFFF : rnd[i];
        end

        pt_next.point_x   = $signed(res[0]);
        pt_next.point_y   = $signed(res[1]);
        pt_next.point_z   = $signed(res[2]);
        pt_next.out_red   = st_reg[NSTG-1].sb.red;
        pt_next.out_green = st_reg[NSTG-1].sb.green;
        pt_next.out_blue  = st_reg[NSTG-1].sb.blue;
        pt_next.out_col   = st_reg[NSTG-1].sb.col;
        pt_next.out_row   = st_reg[NSTG-1].sb.row;
        pt_next.w_zero    = st_reg[NSTG-1].bz;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NSTG; s++)
                st_reg[s] <= st_next[s];
            pt_reg <= pt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-1:0], in_valid};
    end

    assign out_valid = vld_reg[NSTG];
    assign out_point = pt_reg;

endmodule

`default_nettype wire

/* design/depth_pixel_unproject_core.sv */
// Top level of the depth pixel unprojection core: configuration registers, pipeline
// sections and output skid buffer. Depends on dpu_pkg, dpu_ndc, dpu_mat, dpu_wdiv.
//
//   channel | signals                           | moves
//   --------+-----------------------------------+--------------------------------
//   pixel   | pixel_valid, pixel_stall, pixel   | one depth pixel item per cycle unless stalled
//   point   | point_valid, point_stall, point   | one point item, none if dropped
//   cfg     | cfg_write, cfg_index, cfg_data    | register write, no handshake
//
// One item per cycle sustained while pixel_stall is low; an item passes 51 register
// stages between the pixel accept and point_valid. The depth is set by the 10
// radix-16 stages of the pixel-centre divide and the 32 one-bit stages of the divide
// by w. Reset clears valid bits and loads register defaults (640 x 480, full mode).
// A stalled output item parks in the skid register; pixel_stall is that register's
// valid bit, and the whole pipeline holds while it is full.
`default_nettype none

module depth_pixel_unproject_core
    import dpu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pixel_valid,
    output logic                      pixel_stall,
    input  wire pixel_t               pixel,
    output logic                      point_valid,
    input  wire logic                 point_stall,
    output point_t                    point,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]  pack_reg [5];
    logic [ELEM_W-1:0] pack_f_reg;
    logic [25:0]       size_reg;
    logic              full_reg;

    matrix_t           mat;
    logic [DIM_W-1:0]  dim_x, dim_y;
    logic              en;
    logic              keep;

    logic              ndc_valid, mat_valid, div_valid;
    vec_t              ndc_vec;
    hom_t              mat_hom;
    point_t            div_point;

    logic              out_valid_reg, skid_valid_reg;
    point_t            out_reg, skid_reg;
    logic              take;

    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] raw);
        if (raw == '0)
            return DIM_W'(1);
        if (raw > DIM_W'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        return raw;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                pack_reg[i] <= '0;
            pack_f_reg <= '0;
            size_reg   <= 26'd3932800;
            full_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PACK_A:     pack_reg[0] <= cfg_data;
                REG_PACK_B:     pack_reg[1] <= cfg_data;
                REG_PACK_C:     pack_reg[2] <= cfg_data;
                REG_PACK_D:     pack_reg[3] <= cfg_data;
                REG_PACK_E:     pack_reg[4] <= cfg_data;
                REG_PACK_F:     pack_f_reg  <= cfg_data[ELEM_W-1:0];
                REG_IMAGE_SIZE: size_reg    <= cfg_data[25:0];
                REG_FULL_MODE:  full_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // row-major elements, three to a register, lowest field first
    assign mat[0]  = pack_reg[0][20:0];
    assign mat[1]  = pack_reg[0][41:21];
    assign mat[2]  = pack_reg[0][62:42];
    assign mat[3]  = pack_reg[1][20:0];
    assign mat[4]  = pack_reg[1][41:21];
    assign mat[5]  = pack_reg[1][62:42];
    assign mat[6]  = pack_reg[2][20:0];
    assign mat[7]  = pack_reg[2][41:21];
    assign mat[8]  = pack_reg[2][62:42];
    assign mat[9]  = pack_reg[3][20:0];
    assign mat[10] = pack_reg[3][41:21];
    assign mat[11] = pack_reg[3][62:42];
    assign mat[12] = pack_reg[4][20:0];
    assign mat[13] = pack_reg[4][41:21];
    assign mat[14] = pack_reg[4][62:42];
    assign mat[15] = pack_f_reg;

    assign dim_x = dim_of(size_reg[12:0]);
    assign dim_y = dim_of(size_reg[25:13]);

    assign en          = !skid_valid_reg;
    assign pixel_stall = skid_valid_reg;
    // filtered mode: drop zero-depth and background-depth items at the door
    assign keep        = full_reg || (bg_map(pixel.depth_sample) != '0);

    dpu_ndc u_ndc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pixel_valid && keep),
        .in_pix    (pixel),
        .dim_x     (dim_x),
        .dim_y     (dim_y),
        .out_valid (ndc_valid),
        .out_vec   (ndc_vec)
    );

    dpu_mat u_mat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ndc_valid),
        .in_vec    (ndc_vec),
        .mat       (mat),
        .out_valid (mat_valid),
        .out_hom   (mat_hom)
    );

    dpu_wdiv u_wdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mat_valid),
        .in_hom    (mat_hom),
        .out_valid (div_valid),
        .out_point (div_point)
    );

    assign take = out_valid_reg && !point_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // pipeline is held; drain the skid item first
            if (take)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || take)
            out_valid_reg <= div_valid;
        else if (div_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || take)
            out_reg <= div_point;
        else if (div_valid)
            skid_reg <= div_point;
    end

    assign point_valid = out_valid_reg;
    assign point       = out_reg;

endmodule

`default_nettype wire

/* design/dpu_checker.sv */
// Port-level checks for depth_pixel_unproject_core, attached by the bind below.
// Depends on dpu_pkg.
`default_nettype none

module dpu_checker
    import dpu_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   pixel_stall,
    input wire logic   point_valid,
    input wire logic   point_stall,
    input wire point_t point
);

    // output item holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid && $stable(point))
        else $error("point item changed while stalled");

    // input backpressure only follows a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_stall) |-> $past(point_valid && point_stall))
        else $error("pixel_stall rose without output stall");

    // backpressure clears only after the consumer takes an item
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pixel_stall) |-> $past(point_valid && !point_stall))
        else $error("pixel_stall fell without an output take");

    // zero w gives only saturated or zero coordinates
    a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point.w_zero |->
            (point.point_x == 32'sh7FFF_FFFF || point.point_x == 32'sh8000_0000 ||
             point.point_x == 32'sh0) &&
            (point.point_y == 32'sh7FFF_FFFF || point.point_y == 32'sh8000_0000 ||
             point.point_y == 32'sh0) &&
            (point.point_z == 32'sh7FFF_FFFF || point.point_z == 32'sh8000_0000 ||
             point.point_z == 32'sh0))
        else $error("w_zero item with unsaturated coordinate");

endmodule

bind depth_pixel_unproject_core dpu_checker u_dpu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_stall (pixel_stall),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point)
);

`default_nettype wire

/* tb/sv/tb_depth_pixel_unproject_core.sv */
// Testbench for depth_pixel_unproject_core: random and directed pixels, checked against
// a built-in fixed-point predictor. Depends on dpu_pkg and the core RTL only.
`timescale 1ns / 1ps

import dpu_pkg::*;

class point_scoreboard;
    logic [CFG_W-1:0] regs [8];
    point_t           expected_points [$];
    int               mismatches;

    function void reset_regs();
        foreach (regs[i])
            regs[i] = '0;
        regs[REG_IMAGE_SIZE] = 63'd3932800;
        regs[REG_FULL_MODE]  = 63'd1;
        mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        regs[idx] = val;
    endfunction

    function longint elem(int k);
        logic signed [ELEM_W-1:0] e;
        logic [CFG_W-1:0] pk;
        pk = regs[k / 3] >> (ELEM_W * (k % 3));
        e  = pk[ELEM_W-1:0];
        return longint'(e);
    endfunction

    function longint dim_of(logic [12:0] raw);
        longint d;
        d = raw;
        if (d == 0)
            d = 1;
        if (d > MAX_DIM)
            d = MAX_DIM;
        return d;
    endfunction

    // pixel centre to device coordinate, Q.24, round half away from zero
    function longint centre_ndc(longint p, longint dim);
        longint n;
        longint mag;
        longint q;
        n   = 2 * p + 1 - dim;
        mag = (n < 0 ? -n : n) <<< 24;
        q   = (mag + dim / 2) / dim;
        return n < 0 ? -q : q;
    endfunction

    function logic [31:0] div_q16(longint num, longint w);
        bit neg;
        logic [63:0] a, b, q, r, lim;
        if (w == 0)
            return num > 0 ? 32'h7FFF_FFFF : (num < 0 ? 32'h8000_0000 : 32'h0);
        neg = (num < 0) != (w < 0);
        a   = num < 0 ? -num : num;
        b   = w < 0 ? -w : w;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q   = a / b;
        r   = a % b;
        if (q >= 64'h8000)
            return lim[31:0];
        for (int k = 0; k < 17; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= b)
            begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        q = (q + 64'd1) >> 1;
        if (q > lim)
            q = lim;
        return neg ? (32'd0 - q[31:0]) : q[31:0];
    endfunction

    function void note_pixel(pixel_t px);
        logic [DEPTH_W-1:0] d;
        longint v [4];
        longint h [4];
        point_t pt;
        d = px.depth_sample;
        if (d == DEPTH_ONE)
            d = '0;
        if (regs[REG_FULL_MODE][0] == 1'b0 && d == 0)
            return;
        v[0] = centre_ndc(px.pixel_col, dim_of(regs[REG_IMAGE_SIZE][12:0]));
        v[1] = centre_ndc(px.pixel_row, dim_of(regs[REG_IMAGE_SIZE][25:13]));
        v[2] = 2 * longint'(d) - 64'd16777216;
        v[3] = 64'd16777216;
        for (int rr = 0; rr < 4; rr++)
        begin
            h[rr] = 0;
            for (int cc = 0; cc < 4; cc++)
                h[rr] += elem(4 * rr + cc) * v[cc];
        end
        pt.point_x   = div_q16(h[0], h[3]);
        pt.point_y   = div_q16(h[1], h[3]);
        pt.point_z   = div_q16(h[2], h[3]);
        pt.out_red   = px.red;
        pt.out_green = px.green;
        pt.out_blue  = px.blue;
        pt.out_col   = px.pixel_col;
        pt.out_row   = px.pixel_row;
        pt.w_zero    = (h[3] == 0);
        expected_points.insert(expected_points.size(), pt);
    endfunction

    function void report(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h got %h", name, e, a);
        end
    endfunction

    function void check_point(point_t got);
        point_t e;
        if (expected_points.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected point item %h", got);
            return;
        end
        e = expected_points.pop_front();
        report("point_x", e.point_x, got.point_x);
        report("point_y", e.point_y, got.point_y);
        report("point_z", e.point_z, got.point_z);
        report("out_red", e.out_red, got.out_red);
        report("out_green", e.out_green, got.out_green);
        report("out_blue", e.out_blue, got.out_blue);
        report("out_col", e.out_col, got.out_col);
        report("out_row", e.out_row, got.out_row);
        report("w_zero", e.w_zero, got.w_zero);
    endfunction
endclass

module tb_depth_pixel_unproject_core;
    localparam int CYCLE_LIMIT = 400000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_stall;
    pixel_t               pixel = '0;
    logic                 point_valid;
    logic                 point_stall = 1'b0;
    point_t               point;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    point_scoreboard sb;
    int  sender_idle = 0;
    int  stall_pct = 0;
    bit  hold_go = 1'b0;
    logic hold_on = 1'b0;
    int  cycles = 0;

    depth_pixel_unproject_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_depth_pixel_unproject_core: errors");
            $finish;
        end
    end

    always @(posedge clk)
        point_stall <= hold_on || ($urandom_range(99) < stall_pct);

    // long receiver hold-off so the pipeline backs up into the input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (400) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk)
        if (rst_n && point_valid && !point_stall)
            sb.check_point(point);

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic send_pixel(pixel_t px);
        while ($urandom_range(99) < sender_idle)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        do
            @(posedge clk);
        while (pixel_stall);
        sb.note_pixel(px);
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_points.size() > 0)
            @(posedge clk);
        // dropped items may still be in flight
        repeat (70) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] rand_pack(int mode);
        logic [ELEM_W-1:0] e [3];
        for (int i = 0; i < 3; i++)
        begin
            case (mode)
                0: e[i] = 21'($urandom);
                1: e[i] = 21'($signed($urandom_range(0, 262144)) - 131072);
                2: e[i] = 21'h0F_FFFF;
                default: e[i] = 21'h10_0000;
            endcase
        end
        return {e[2], e[1], e[0]};
    endfunction

    task automatic load_matrix(int mode);
        write_reg(REG_PACK_A, rand_pack(mode));
        write_reg(REG_PACK_B, rand_pack(mode));
        write_reg(REG_PACK_C, rand_pack(mode));
        write_reg(REG_PACK_D, rand_pack(mode));
        write_reg(REG_PACK_E, rand_pack(mode));
        write_reg(REG_PACK_F, rand_pack(mode) & 63'h1F_FFFF);
    endtask

    function automatic pixel_t rand_pixel(int wd, int ht);
        pixel_t px;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        px  = raw[$bits(pixel_t)-1:0];
        case ($urandom_range(9))
            0: px.depth_sample = DEPTH_ONE;
            1: px.depth_sample = '0;
            2, 3: ;
            default: px.depth_sample = 25'($urandom_range(0, 16777215));
        endcase
        if ($urandom_range(9) < 8)
        begin
            px.pixel_col = 12'($urandom_range(0, wd - 1));
            px.pixel_row = 12'($urandom_range(0, ht - 1));
        end
        return px;
    endfunction

    task automatic random_phase(int n, int wd, int ht);
        for (int i = 0; i < n; i++)
            send_pixel(rand_pixel(wd, ht));
    endtask

    initial
    begin
        pixel_t px;
        sb = new();
        sb.reset_regs();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity-like matrix, corners, depth specials, colors
        write_reg(REG_PACK_A, {21'd0, 21'd0, 21'd65536});
        write_reg(REG_PACK_B, {21'd65536, 21'd0, 21'd0});
        write_reg(REG_PACK_C, {21'd0, 21'd0, 21'd0});
        write_reg(REG_PACK_D, {21'd0, 21'd65536, 21'd0});
        write_reg(REG_PACK_E, {21'd0, 21'd0, 21'd0});
        write_reg(REG_PACK_F, 63'd65536);
        for (int i = 0; i < 12; i++)
        begin
            px.pixel_col = (i & 1) ? 12'd4095 : 12'd0;
            px.pixel_row = (i & 2) ? 12'd4095 : 12'd0;
            case (i % 4)
                0: px.depth_sample = '0;
                1: px.depth_sample = DEPTH_ONE;
                2: px.depth_sample = 25'h1FF_FFFF;
                default: px.depth_sample = 25'd8388608;
            endcase
            px.red   = (i & 4) ? 8'hFF : 8'h00;
            px.green = (i & 4) ? 8'h00 : 8'hFF;
            px.blue  = 8'hFF;
            send_pixel(px);
        end
        px = '{12'd639, 12'd479, 25'd100, 8'd1, 8'd2, 8'd3};
        send_pixel(px);
        drain();
        // zero w, zero size, full-scale elements, filtered-mode drops
        write_reg(REG_PACK_F, 63'd0);
        write_reg(REG_PACK_E, 63'd0);
        write_reg(REG_IMAGE_SIZE, 63'd0);
        for (int i = 0; i < 4; i++)
            send_pixel(rand_pixel(1, 1));
        drain();
        load_matrix(2);
        write_reg(REG_IMAGE_SIZE, 63'h3FF_FFFF);
        send_pixel(rand_pixel(4096, 4096));
        send_pixel(rand_pixel(4096, 4096));
        drain();
        load_matrix(3);
        write_reg(REG_FULL_MODE, 63'd0);
        px = '{12'd5, 12'd5, 25'd0, 8'd9, 8'd9, 8'd9};
        send_pixel(px);
        px.depth_sample = DEPTH_ONE;
        send_pixel(px);
        px.depth_sample = 25'd1;
        send_pixel(px);
        drain();

        // random phases
        sender_idle = 0;  stall_pct = 0;
        load_matrix(1);
        write_reg(REG_IMAGE_SIZE, 63'({13'd48, 13'd64}));
        write_reg(REG_FULL_MODE, 63'd1);
        random_phase(60, 64, 48);
        hold_go = 1'b1;
        random_phase(120, 64, 48);
        drain();

        sender_idle = 75; stall_pct = 0;
        load_matrix(0);
        write_reg(REG_IMAGE_SIZE, 63'({13'd480, 13'd640}));
        write_reg(REG_FULL_MODE, 63'd0);
        random_phase(80, 640, 480);
        drain();

        sender_idle = 0;  stall_pct = 75;
        load_matrix(1);
        write_reg(REG_IMAGE_SIZE, 63'({13'd16, 13'd4096}));
        random_phase(80, 4096, 16);
        drain();

        sender_idle = 24; stall_pct = 24;
        load_matrix(1);
        write_reg(REG_IMAGE_SIZE, 63'({13'd4096, 13'd1}));
        write_reg(REG_FULL_MODE, 63'd1);
        random_phase(80, 1, 4096);
        sender_idle = 0;  stall_pct = 0;
        random_phase(30, 1, 4096);
        drain();

        if (sb.mismatches == 0 && sb.expected_points.size() == 0)
            $display("tb_depth_pixel_unproject_core: clean");
        else
            $display("tb_depth_pixel_unproject_core: errors");
        $finish;
    end
endmodule

/* filelist.f */
design/dpu_pkg.sv
design/dpu_ndc.sv
design/dpu_mat.sv
design/dpu_wdiv.sv
design/depth_pixel_unproject_core.sv
design/dpu_checker.sv
tb/sv/tb_depth_pixel_unproject_core.sv
